@@ src/uedt_pkg.sv @@
// ----------------------------------------------------------------------------
// uedt_pkg
// Shared types and constants for the unordered edge dedup table.
// ----------------------------------------------------------------------------
package uedt_pkg;

	localparam int CAPACITY_DEF    = 256;
	localparam int VERTEX_BITS_DEF = 16;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LAUNCH,
		ST_SEARCH,
		ST_DONE
	} uedt_state_t;

	// search transaction travelling along the cell row
	typedef struct packed {
		logic vld;
		logic hit;
	} tok_ctl_t;

endpackage

@@ src/uedt_cell.sv @@
// ----------------------------------------------------------------------------
// uedt_cell
// One table entry: holds an edge, compares it against the passing search
// transaction in both orientations and forwards the transaction one step.
// ----------------------------------------------------------------------------
module uedt_cell import uedt_pkg::*; #(
	parameter int VB       = VERTEX_BITS_DEF,
	parameter int IW       = 8,
	parameter int CW       = 9,
	parameter int CELL_IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tok_ctl_t      ctl_in,
	input  logic [IW-1:0] idx_in,
	input  logic [VB-1:0] a,
	input  logic [VB-1:0] b,
	input  logic [CW-1:0] count,
	input  logic          wr_en,
	input  logic [IW-1:0] wr_idx,
	output tok_ctl_t      ctl_out,
	output logic [IW-1:0] idx_out
);

	logic [VB-1:0] first_q;
	logic [VB-1:0] second_q;
	logic          live;
	logic          match;
	tok_ctl_t      ctl_q;
	logic [IW-1:0] idx_q;

	assign live  = CW'(CELL_IDX) < count;
	assign match = ctl_in.vld && !ctl_in.hit && live &&
		((first_q == a && second_q == b) || (first_q == b && second_q == a));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q.vld <= ctl_in.vld;
			ctl_q.hit <= ctl_in.hit || match;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= match ? IW'(CELL_IDX) : idx_in;
		if (wr_en && wr_idx == IW'(CELL_IDX)) begin
			first_q  <= a;
			second_q <= b;
		end
	end

	assign ctl_out = ctl_q;
	assign idx_out = idx_q;

endmodule

@@ src/unordered_edge_dedup_table.sv @@
// ----------------------------------------------------------------------------
// unordered_edge_dedup_table
// Find-or-insert table of undirected edges built as a row of compare cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries op, vertex_a, vertex_b. An add
//   searches the stored edges in either orientation and reports the lowest
//   matching index; on a miss the edge is appended if the table has room,
//   else table_full is reported. A clear empties the table. Output channel
//   (out_valid/out_ready) carries one result per transaction: edge_index,
//   was_present, table_full, edge_count. An add walks a search transaction
//   through CAPACITY cells, one cell per clock, before its result is
//   registered; a clear skips the search. One transaction is in flight at
//   a time: no new transaction is accepted until the previous one has
//   finished and its result has been loaded into the output register.
//   The result sits in an output register; the next transaction is accepted
//   while it waits. If the receiver stalls, a finished result is held until
//   the output register frees and no further input is taken meanwhile.
//   Reset empties the table (count to zero); stored words are left as they
//   are and are never compared before being rewritten.
// ----------------------------------------------------------------------------
module unordered_edge_dedup_table import uedt_pkg::*; #(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int VERTEX_BITS = VERTEX_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [15:0] vertex_a,
	input  logic [15:0] vertex_b,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  edge_index,
	output logic        was_present,
	output logic        table_full,
	output logic [8:0]  edge_count
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	uedt_state_t          state_q, state_d;
	logic [VERTEX_BITS-1:0] a_q, b_q;
	logic [CW-1:0]        count_q;
	logic                 in_acc;
	logic                 launch;
	logic                 load_out;
	logic                 wr_en;
	logic                 room;

	logic [IW-1:0]        pend_idx_q;
	logic                 pend_present_q;
	logic                 pend_full_q;
	logic [CW-1:0]        pend_count_q;

	logic                 out_vld_q;
	logic [7:0]           out_idx_q;
	logic                 out_present_q;
	logic                 out_full_q;
	logic [8:0]           out_count_q;

	tok_ctl_t             ctl_w [CAPACITY+1];
	logic [IW-1:0]        idx_w [CAPACITY+1];
	tok_ctl_t             tail;

	assign in_acc = in_valid && in_ready;
	assign tail   = ctl_w[CAPACITY];
	assign room   = count_q < CW'(CAPACITY);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = (op == OP_CLEAR) ? ST_DONE : ST_LAUNCH;
				end
			end
			ST_LAUNCH: begin
				state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (tail.vld) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_vld_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		launch   = 1'b0;
		load_out = 1'b0;
		wr_en    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_LAUNCH: begin
				launch = 1'b1;
			end
			ST_SEARCH: begin
				wr_en = tail.vld && !tail.hit && room;
			end
			ST_DONE: begin
				load_out = !out_vld_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc && op == OP_CLEAR) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + CW'(1);
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			a_q            <= VERTEX_BITS'(vertex_a);
			b_q            <= VERTEX_BITS'(vertex_b);
			pend_idx_q     <= '0;
			pend_present_q <= 1'b0;
			pend_full_q    <= 1'b0;
			pend_count_q   <= '0;
		end
		if (state_q == ST_SEARCH && tail.vld) begin
			pend_present_q <= tail.hit;
			if (tail.hit) begin
				pend_idx_q   <= idx_w[CAPACITY];
				pend_full_q  <= 1'b0;
				pend_count_q <= count_q;
			end else if (room) begin
				pend_idx_q   <= IW'(count_q);
				pend_full_q  <= 1'b0;
				pend_count_q <= count_q + CW'(1);
			end else begin
				pend_idx_q   <= '0;
				pend_full_q  <= 1'b1;
				pend_count_q <= count_q;
			end
		end
		if (load_out) begin
			out_idx_q     <= 8'(pend_idx_q);
			out_present_q <= pend_present_q;
			out_full_q    <= pend_full_q;
			out_count_q   <= 9'(pend_count_q);
		end
	end

	assign ctl_w[0].vld = launch;
	assign ctl_w[0].hit = 1'b0;
	assign idx_w[0]     = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		uedt_cell #(
			.VB      (VERTEX_BITS),
			.IW      (IW),
			.CW      (CW),
			.CELL_IDX(i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_in (ctl_w[i]),
			.idx_in (idx_w[i]),
			.a      (a_q),
			.b      (b_q),
			.count  (count_q),
			.wr_en  (wr_en),
			.wr_idx (IW'(count_q)),
			.ctl_out(ctl_w[i+1]),
			.idx_out(idx_w[i+1])
		);
	end

	assign out_valid   = out_vld_q;
	assign edge_index  = out_idx_q;
	assign was_present = out_present_q;
	assign table_full  = out_full_q;
	assign edge_count  = out_count_q;

endmodule

@@ test/tb_unordered_edge_dedup_table.sv @@
// ----------------------------------------------------------------------------
// tb_unordered_edge_dedup_table
// Self-checking bench for the unordered edge dedup table.
// A short table of directed transactions covers reset, field extremes,
// swapped orientation, degenerate edges and clears. A long random run then
// fills the table to capacity, exercises hits and refused adds while full,
// and empties it again. Every result is compared field by field with the
// directed row's typed result, if any, else an in-bench find-or-insert
// predictor. Both channels idle and stall at random, save one flat-out run.
// ----------------------------------------------------------------------------
module tb_unordered_edge_dedup_table;
	import uedt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH    = CAPACITY_DEF;
	localparam int VTX_BITS       = VERTEX_BITS_DEF;
	localparam logic [15:0] VTX_MASK = 16'((32'd1 << VTX_BITS) - 1);
	localparam int RANDOM_ITEMS   = 800;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic [7:0] idx;
		logic       present;
		logic       full;
		logic [8:0] count;
	} edge_result_t;

	typedef struct packed {
		logic         cmd;
		logic [15:0]  va;
		logic [15:0]  vb;
		bit           typed;
		edge_result_t res;
	} stim_row_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic        op        = OP_ADD;
	logic [15:0] vertex_a  = '0;
	logic [15:0] vertex_b  = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  edge_index;
	logic        was_present;
	logic        table_full;
	logic [8:0]  edge_count;

	bit  steady       = 1'b0;
	int  stall_left   = 0;
	int  idle_cycles  = 0;
	int  mismatches   = 0;
	int  results_seen = 0;

	// predictor state
	logic [15:0] first_vtx  [TABLE_DEPTH];
	logic [15:0] second_vtx [TABLE_DEPTH];
	int          stored_edges = 0;

	edge_result_t expected_results[$];

	stim_row_t directed_rows[] = '{
		'{OP_ADD,   16'h0000, 16'h0000, 1'b1, '{8'd0, 1'b0, 1'b0, 9'd1}},
		'{OP_ADD,   16'h0000, 16'h0000, 1'b1, '{8'd0, 1'b1, 1'b0, 9'd1}},
		'{OP_ADD,   16'hFFFF, 16'h0000, 1'b1, '{8'd1, 1'b0, 1'b0, 9'd2}},
		'{OP_ADD,   16'h0000, 16'hFFFF, 1'b1, '{8'd1, 1'b1, 1'b0, 9'd2}},
		'{OP_ADD,   16'hFFFF, 16'hFFFF, 1'b1, '{8'd2, 1'b0, 1'b0, 9'd3}},
		'{OP_ADD,   16'h1234, 16'hABCD, 1'b0, '0},
		'{OP_ADD,   16'hABCD, 16'h1234, 1'b0, '0},
		'{OP_ADD,   16'h5555, 16'hAAAA, 1'b0, '0},
		'{OP_ADD,   16'hAAAA, 16'h5555, 1'b0, '0},
		'{OP_ADD,   16'h0007, 16'h0007, 1'b0, '0},
		'{OP_ADD,   16'h0007, 16'h0007, 1'b0, '0},
		'{OP_ADD,   16'h0007, 16'h0008, 1'b0, '0},
		'{OP_ADD,   16'hFFFF, 16'h0000, 1'b0, '0},
		'{OP_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1, '{8'd0, 1'b0, 1'b0, 9'd0}},
		'{OP_CLEAR, 16'h0000, 16'h0000, 1'b1, '{8'd0, 1'b0, 1'b0, 9'd0}},
		'{OP_ADD,   16'hFFFF, 16'h0000, 1'b1, '{8'd0, 1'b0, 1'b0, 9'd1}},
		'{OP_ADD,   16'h0000, 16'h0000, 1'b1, '{8'd1, 1'b0, 1'b0, 9'd2}},
		'{OP_ADD,   16'h0000, 16'hFFFF, 1'b1, '{8'd0, 1'b1, 1'b0, 9'd2}},
		'{OP_ADD,   16'h8000, 16'h0001, 1'b0, '0},
		'{OP_ADD,   16'h0001, 16'h8000, 1'b0, '0},
		'{OP_CLEAR, 16'h1234, 16'h5678, 1'b1, '{8'd0, 1'b0, 1'b0, 9'd0}}
	};

	unordered_edge_dedup_table #(
		.CAPACITY    (TABLE_DEPTH),
		.VERTEX_BITS (VTX_BITS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.vertex_a    (vertex_a),
		.vertex_b    (vertex_b),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.edge_index  (edge_index),
		.was_present (was_present),
		.table_full  (table_full),
		.edge_count  (edge_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic edge_result_t find_or_insert(input logic cmd,
			input logic [15:0] va, input logic [15:0] vb);
		edge_result_t r;
		logic [15:0]  a;
		logic [15:0]  b;
		bit           hit;
		r   = '0;
		hit = 1'b0;
		a   = va & VTX_MASK;
		b   = vb & VTX_MASK;
		if (cmd == OP_CLEAR) begin
			stored_edges = 0;
		end else begin
			for (int i = 0; i < stored_edges && !hit; i++) begin
				if ((first_vtx[i] == a && second_vtx[i] == b) ||
						(first_vtx[i] == b && second_vtx[i] == a)) begin
					r.idx = i[7:0];
					hit   = 1'b1;
				end
			end
			if (hit) begin
				r.present = 1'b1;
			end else if (stored_edges >= TABLE_DEPTH) begin
				r.full = 1'b1;
			end else begin
				first_vtx[stored_edges]  = a;
				second_vtx[stored_edges] = b;
				r.idx = stored_edges[7:0];
				stored_edges++;
			end
		end
		r.count = stored_edges[8:0];
		return r;
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("mismatch %s: got %0d, expected %0d (result %0d)",
			field, got, want, results_seen);
		mismatches++;
	endtask

	// one transaction on the input channel, then an optional random gap
	task automatic issue(input logic cmd, input logic [15:0] va, input logic [15:0] vb,
			input bit typed, input edge_result_t typed_res);
		edge_result_t predicted;
		int           gap;
		in_valid <= 1'b1;
		op       <= cmd;
		vertex_a <= va;
		vertex_b <= vb;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = find_or_insert(cmd, va, vb);
		expected_results.push_back(typed ? typed_res : predicted);
		gap = 0;
		if (!steady) begin
			while ($urandom_range(0, 99) < 34)
				gap++;
			if ($urandom_range(0, 15) == 0)
				gap += $urandom_range(1, TABLE_DEPTH + 4);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			op       <= 1'($urandom);
			vertex_a <= 16'($urandom);
			vertex_b <= 16'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if (!steady && $urandom_range(0, 299) == 0) begin
			stall_left <= $urandom_range(1, TABLE_DEPTH + 4);
			out_ready  <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(0, 99) >= 34);
		end
	end

	always @(posedge clk) begin : check_results
		edge_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing outstanding", edge_index, 0);
			end else begin
				want = expected_results.pop_front();
				if (edge_index !== want.idx)
					report_mismatch("edge_index", edge_index, want.idx);
				if (was_present !== want.present)
					report_mismatch("was_present", was_present, want.present);
				if (table_full !== want.full)
					report_mismatch("table_full", table_full, want.full);
				if (edge_count !== want.count)
					report_mismatch("edge_count", edge_count, want.count);
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		logic        cmd;
		logic [15:0] va;
		logic [15:0] vb;
		logic [15:0] tmp;
		int          roll;
		int          pick;
		bit          reached_full;
		reached_full = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k])
			issue(directed_rows[k].cmd, directed_rows[k].va, directed_rows[k].vb,
				directed_rows[k].typed, directed_rows[k].res);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady <= (n >= 300 && n < 380);
			if (stored_edges >= TABLE_DEPTH)
				reached_full = 1'b1;
			roll = $urandom_range(0, 999);
			va   = 16'($urandom);
			vb   = 16'($urandom);
			cmd  = OP_ADD;
			if (stored_edges >= TABLE_DEPTH ? roll < 30 : (reached_full && roll < 5)) begin
				cmd = OP_CLEAR;
			end else begin
				pick = $urandom_range(0, 19);
				if (pick >= 9 && pick <= 13) begin
					// small vertex pool: frequent repeats
					va = 16'($urandom_range(0, 7));
					vb = 16'($urandom_range(0, 7));
				end else if (pick >= 14 && pick <= 17 && stored_edges > 0) begin
					roll = $urandom_range(0, stored_edges - 1);
					va   = first_vtx[roll];
					vb   = second_vtx[roll];
					if ($urandom_range(0, 1)) begin
						tmp = va;
						va  = vb;
						vb  = tmp;
					end
				end else if (pick >= 18) begin
					if ($urandom_range(0, 1))
						va = 16'($urandom_range(0, 7));
					vb = va;
				end
			end
			issue(cmd, va, vb, 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
